>>> src/cae_pkg.sv
// shared types and constants for the alu and move executor
`timescale 1ns / 1ps
package cae_pkg;

    localparam logic [3:0] OP_STORE = 4'd0;
    localparam logic [3:0] OP_MVI   = 4'd1;
    localparam logic [3:0] OP_MOV   = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_ADC   = 4'd4;
    localparam logic [3:0] OP_ADI   = 4'd5;
    localparam logic [3:0] OP_ACI   = 4'd6;
    localparam logic [3:0] OP_SUB   = 4'd7;
    localparam logic [3:0] OP_SBB   = 4'd8;
    localparam logic [3:0] OP_SUI   = 4'd9;
    localparam logic [3:0] OP_SBI   = 4'd10;
    localparam logic [3:0] OP_INR   = 4'd11;
    localparam logic [3:0] OP_DCR   = 4'd12;
    localparam logic [3:0] OP_LXI   = 4'd13;
    localparam logic [3:0] OP_JMP   = 4'd14;

    localparam logic [2:0] CODE_H = 3'd4;
    localparam logic [2:0] CODE_L = 3'd5;
    localparam logic [2:0] CODE_M = 3'd6;
    localparam logic [2:0] CODE_A = 3'd7;
    // slot of the accumulator in the register file
    localparam logic [2:0] IDX_A  = 3'd6;
    localparam int         NUM_REGS = 7;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  tgt;
        logic [2:0]  src;
        logic [15:0] imm;
        logic [7:0]  sdat;
        logic        rd_mem;
    } cae_item_t;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  wv;
        logic        z;
        logic        s;
        logic        p;
        logic        cy;
        logic [15:0] pc;
    } cae_res_t;

    typedef struct packed {
        logic clearing;
        logic rd_pend;
    } cae_stat_t;

endpackage

>>> src/cpu8_alu_and_move_executor.sv
// top level: 8-bit alu and move executor with queue interfaces
// an accepted beat is registered in the input queue, then executed into the
// result queue; a memory operand at h:l first takes one registered read of the
// byte memory. throughput: one item per cycle while the result queue has room;
// an item with a memory operand waits for its read. reset: registers, flags and
// pc clear at once; then a clearing pass zeroes the byte memory while full stays high
`timescale 1ns / 1ps
module cpu8_alu_and_move_executor #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  op,
    input  logic [2:0]  target_reg,
    input  logic [2:0]  operand_reg,
    input  logic [15:0] immediate,
    input  logic [7:0]  store_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  acc_value,
    output logic [7:0]  written_value,
    output logic        zero_flag,
    output logic        sign_flag,
    output logic        parity_flag,
    output logic        carry_flag,
    output logic [15:0] pc_value
);
    import cae_pkg::*;

    logic      item_valid;
    logic      item_take;
    cae_item_t item;
    cae_stat_t stat;
    cae_res_t  res;

    cae_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold        (stat.clearing),
        .push        (push),
        .full        (full),
        .op          (op),
        .target_reg  (target_reg),
        .operand_reg (operand_reg),
        .immediate   (immediate),
        .store_data  (store_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    cae_back #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .stat       (stat),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign acc_value     = res.acc;
    assign written_value = res.wv;
    assign zero_flag     = res.z;
    assign sign_flag     = res.s;
    assign parity_flag   = res.p;
    assign carry_flag    = res.cy;
    assign pc_value      = res.pc;

    // no beat taken while memory is being cleared
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> full)
        else $error("input accepted during clearing pass");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> empty)
        else $error("result produced during clearing pass");

    a_read_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.rd_pend |-> !stat.clearing && item_valid)
        else $error("memory read pending without an item");
endmodule

>>> src/cae_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module cae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/cae_front.sv
// front end: input queue and operand classification
`timescale 1ns / 1ps
module cae_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hold,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         op,
    input  logic [2:0]         target_reg,
    input  logic [2:0]         operand_reg,
    input  logic [15:0]        immediate,
    input  logic [7:0]         store_data,
    output logic               item_valid,
    output cae_pkg::cae_item_t item,
    input  logic               item_take
);
    import cae_pkg::*;

    cae_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       acc_beat;
    logic       take_beat;
    logic       uses_src;
    cae_item_t  new_item;

    assign full      = (cnt_reg == 2'd2) || hold;
    assign acc_beat  = push && !full;
    assign take_beat = item_take && (cnt_reg != 2'd0);

    // ops whose operand may be memory at h:l
    always_comb
    begin
        unique case (op)
            OP_MOV, OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_INR, OP_DCR: uses_src = 1'b1;
            default: uses_src = 1'b0;
        endcase
    end

    always_comb
    begin
        new_item.op     = op;
        new_item.tgt    = target_reg;
        new_item.src    = operand_reg;
        new_item.imm    = immediate;
        new_item.sdat   = store_data;
        new_item.rd_mem = uses_src && (operand_reg == CODE_M);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ acc_beat;
        rd_ptr_next = rd_ptr_reg ^ take_beat;
        cnt_next    = cnt_reg + {1'b0, acc_beat} - {1'b0, take_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_beat)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
endmodule

>>> src/cae_back.sv
// back end: register file, flags, memory access and result queue
`timescale 1ns / 1ps
module cae_back #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  cae_pkg::cae_item_t item,
    output logic               item_take,
    output cae_pkg::cae_stat_t stat,
    output logic               empty,
    input  logic               pop,
    output cae_pkg::cae_res_t  res
);
    import cae_pkg::*;

    localparam int AW = MEM_ADDR_BITS;

    logic [7:0]    regs_reg [NUM_REGS];
    logic [7:0]    regs_next [NUM_REGS];
    logic          z_reg, s_reg, p_reg, cy_reg;
    logic          z_next, s_next, p_next, cy_next;
    logic [15:0]   pc_reg, pc_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    cae_res_t      oq_reg [2];
    logic          owr_reg, ord_reg;
    logic [1:0]    ocnt_reg, ocnt_next;
    logic          out_beat;

    logic          go, issue_rd, exec;
    logic [15:0]   hl16;
    logic [AW-1:0] hl_addr;
    logic [7:0]    rdata;
    logic [7:0]    src_val, opnd, ib;
    logic          cin;
    logic [8:0]    sum9, sub9;
    logic [7:0]    res8, wv;
    logic          zsp_upd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    cae_res_t      new_res;

    assign hl16    = {regs_reg[CODE_H], regs_reg[CODE_L]};
    assign hl_addr = hl16[AW-1:0];
    assign ib      = item.imm[7:0];

    assign out_beat  = pop && (ocnt_reg != 2'd0);
    assign go        = item_valid && !clearing_reg && (ocnt_reg != 2'd2);
    assign issue_rd  = go && item.rd_mem && !rd_pend_reg;
    assign exec      = go && (!item.rd_mem || rd_pend_reg);
    assign item_take = exec;

    always_comb
    begin
        if (item.src == CODE_A)
        begin
            src_val = regs_reg[IDX_A];
        end
        else if (item.src == CODE_M)
        begin
            src_val = 8'h00;
        end
        else
        begin
            src_val = regs_reg[item.src];
        end
    end

    assign opnd = rd_pend_reg ? rdata : src_val;

    always_comb
    begin
        unique case (item.op)
            OP_ADC, OP_ACI, OP_SBB, OP_SBI: cin = cy_reg;
            default: cin = 1'b0;
        endcase
    end

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] v;
        b = 8'h00;
        v = 8'h00;
        unique case (item.op)
            OP_ADI, OP_ACI, OP_SUI, OP_SBI: b = ib;
            default: b = opnd;
        endcase
        sum9 = {1'b0, regs_reg[IDX_A]} + {1'b0, b} + {8'h00, cin};
        sub9 = {1'b0, b} + {8'h00, cin};

        for (int i = 0; i < NUM_REGS; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        z_next    = z_reg;
        s_next    = s_reg;
        p_next    = p_reg;
        cy_next   = cy_reg;
        pc_next   = pc_reg;
        wv        = 8'h00;
        res8      = 8'h00;
        zsp_upd   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = hl_addr;
        mem_wdata = 8'h00;

        unique case (item.op)
            OP_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = item.imm[AW-1:0];
                mem_wdata = item.sdat;
                wv        = item.sdat;
            end
            OP_MVI, OP_MOV:
            begin
                v  = (item.op == OP_MVI) ? ib : opnd;
                wv = v;
                if (item.tgt == CODE_M)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = v;
                end
                else if (item.tgt == CODE_A)
                begin
                    regs_next[IDX_A] = v;
                end
                else
                begin
                    regs_next[item.tgt] = v;
                end
            end
            OP_ADD, OP_ADC, OP_ADI, OP_ACI:
            begin
                res8             = sum9[7:0];
                regs_next[IDX_A] = res8;
                cy_next          = sum9[8];
                zsp_upd          = 1'b1;
                wv               = res8;
            end
            OP_SUB, OP_SBB, OP_SUI, OP_SBI:
            begin
                res8             = regs_reg[IDX_A] - sub9[7:0];
                regs_next[IDX_A] = res8;
                cy_next          = ({1'b0, regs_reg[IDX_A]} < sub9);
                zsp_upd          = 1'b1;
                wv               = res8;
            end
            OP_INR, OP_DCR:
            begin
                res8    = (item.op == OP_INR) ? opnd + 8'd1 : opnd - 8'd1;
                zsp_upd = 1'b1;
                wv      = res8;
                if (item.src == CODE_M)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = res8;
                end
                else if (item.src == CODE_A)
                begin
                    regs_next[IDX_A] = res8;
                end
                else
                begin
                    regs_next[item.src] = res8;
                end
            end
            OP_LXI:
            begin
                if (item.tgt <= 3'd2)
                begin
                    regs_next[{item.tgt[1:0], 1'b0}] = item.imm[15:8];
                    regs_next[{item.tgt[1:0], 1'b1}] = ib;
                    wv = ib;
                end
            end
            OP_JMP:
            begin
                pc_next = item.imm;
            end
            default:
            begin
                wv = 8'h00;
            end
        endcase

        if (zsp_upd)
        begin
            z_next = (res8 == 8'h00);
            s_next = res8[7];
            p_next = ~(^res8);
        end
    end

    always_comb
    begin
        new_res.acc = regs_next[IDX_A];
        new_res.wv  = wv;
        new_res.z   = z_next;
        new_res.s   = s_next;
        new_res.p   = p_next;
        new_res.cy  = cy_next;
        new_res.pc  = pc_next;
    end

    always_comb
    begin
        rd_pend_next  = rd_pend_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (issue_rd)
        begin
            rd_pend_next = 1'b1;
        end
        else if (exec)
        begin
            rd_pend_next = 1'b0;
        end
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {AW{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
        ocnt_next = ocnt_reg + {1'b0, exec} - {1'b0, out_beat};
    end

    // clearing pass owns the write port after reset
    assign ram_we    = clearing_reg || (exec && mem_we);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : mem_waddr;
    assign ram_wdata = clearing_reg ? 8'h00 : mem_wdata;

    cae_ram #(
        .WIDTH (8),
        .DEPTH (1 << AW)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue_rd),
        .raddr (hl_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
            z_reg        <= 1'b0;
            s_reg        <= 1'b0;
            p_reg        <= 1'b0;
            cy_reg       <= 1'b0;
            pc_reg       <= 16'h0000;
            rd_pend_reg  <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            owr_reg      <= 1'b0;
            ord_reg      <= 1'b0;
            ocnt_reg     <= 2'd0;
        end
        else
        begin
            if (exec)
            begin
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    regs_reg[i] <= regs_next[i];
                end
                z_reg   <= z_next;
                s_reg   <= s_next;
                p_reg   <= p_next;
                cy_reg  <= cy_next;
                pc_reg  <= pc_next;
                owr_reg <= ~owr_reg;
            end
            if (out_beat)
            begin
                ord_reg <= ~ord_reg;
            end
            rd_pend_reg  <= rd_pend_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            ocnt_reg     <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            oq_reg[owr_reg] <= new_res;
        end
    end

    assign empty         = (ocnt_reg == 2'd0);
    assign res           = oq_reg[ord_reg];
    assign stat.clearing = clearing_reg;
    assign stat.rd_pend  = rd_pend_reg;
endmodule
